### hw/rtl/longest_balanced_bracket_run_macros.svh
// Assertion macros shared by the checker of the bracket run block.
`ifndef LONGEST_BALANCED_BRACKET_RUN_MACROS_SVH
`define LONGEST_BALANCED_BRACKET_RUN_MACROS_SVH

// Holds at every edge outside reset.
`define LBBR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent at one edge, consequent at the next.
`define LBBR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lbbr_pkg.sv
// Types and constants of the longest balanced bracket run block.
`default_nettype none

package lbbr_pkg;

  localparam int unsigned FIELD_W = 13;
  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

  localparam logic [7:0] OPEN_SYM  = 8'd40;
  localparam logic [7:0] CLOSE_SYM = 8'd41;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [FIELD_W-1:0] run_length;
    logic [FIELD_W-1:0] best_length;
    logic [FIELD_W-1:0] best_count;
    logic               final_res;
    logic               too_long;
  } out_beat_t;

  // Controls of one update step.
  typedef struct packed {
    logic full;
    logic is_close;
    logic prev_open;
    logic span_ok;
    logic rd_open;
  } step_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/lbbr_store.sv
// Run store: per byte, its open mark and the run of the byte before it.
`default_nettype none

module lbbr_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned DW    = 14
) (
  input  wire logic                     clk_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DW-1:0]            rdata_o,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/lbbr_calc.sv
// Run length of one byte and the running best length and hit count.
`default_nettype none

module lbbr_calc #(
  parameter int unsigned LW = 13
) (
  input  wire lbbr_pkg::step_ctl_t ctl_i,
  input  wire logic [LW-1:0]       prev_run_i,
  input  wire logic [LW-1:0]       prev2_run_i,
  input  wire logic [LW-1:0]       rd_run_i,
  input  wire logic [LW-1:0]       best_i,
  input  wire logic [LW-1:0]       hits_i,
  output logic      [LW-1:0]       run_o,
  output logic      [LW-1:0]       best_o,
  output logic      [LW-1:0]       hits_o
);

  always_comb begin
    run_o = '0;
    if (!ctl_i.full && ctl_i.is_close) begin
      if (ctl_i.prev_open) begin
        run_o = prev2_run_i + LW'(2);
      end else if (ctl_i.span_ok && ctl_i.rd_open) begin
        run_o = rd_run_i + prev_run_i + LW'(2);
      end
    end
  end

  always_comb begin
    best_o = best_i;
    hits_o = hits_i;
    if (!ctl_i.full) begin
      if (run_o == best_i) begin
        hits_o = hits_i + LW'(1);
      end else if (run_o > best_i) begin
        best_o = run_o;
        hits_o = LW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/longest_balanced_bracket_run.sv
// Top level of the longest balanced bracket run block.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+----------------------
//  input    | in  | in_valid_i/in_ready_o  | in_data_i  (in_beat_t)
//  result   | out | out_valid_o/out_ready_i| out_data_o (out_beat_t)
//
// A new byte is taken only once the last one is updated: the store read at accept
// is registered and feeds the update, and the next read address needs its run length.
// One result beat per input beat, held in an output register; one more byte
// can be accepted while a result waits. Reset clears position and best state;
// store contents need no clearing.
`default_nettype none

module longest_balanced_bracket_run #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lbbr_pkg::in_beat_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lbbr_pkg::out_beat_t     out_data_o
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = (LW > lbbr_pkg::FIELD_W) ? LW : lbbr_pkg::FIELD_W;

  function automatic logic [lbbr_pkg::FIELD_W-1:0] sat_field(input logic [LW-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w > CW'(lbbr_pkg::FIELD_MAX)) begin
      return lbbr_pkg::FIELD_MAX;
    end
    return w[lbbr_pkg::FIELD_W-1:0];
  endfunction

  logic          accept, done;
  logic          s1_valid_q, s1_valid_d;
  logic          s1_close_q, s1_open_q, s1_last_q, s1_full_q, s1_span_q;
  logic [LW-1:0] pos_q, pos_d;
  logic [LW-1:0] prev_run_q, prev_run_d;
  logic [LW-1:0] prev2_run_q, prev2_run_d;
  logic          prev_open_q, prev_open_d;
  logic [LW-1:0] best_q, best_d;
  logic [LW-1:0] hits_q, hits_d;
  logic          ovf_q, ovf_d;
  logic          out_valid_q, out_valid_d;
  lbbr_pkg::out_beat_t out_q;

  logic [LW-1:0] rd_ofs;
  logic [LW:0]   rdata;
  logic [LW-1:0] run;
  lbbr_pkg::step_ctl_t ctl;

  assign in_ready_o  = !s1_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign done        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign rd_ofs      = pos_q - prev_run_q - LW'(1);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  lbbr_store #(
    .DEPTH(MAX_LEN),
    .DW   (LW + 1)
  ) u_store (
    .clk_i  (clk_i),
    .re_i   (accept),
    .raddr_i(rd_ofs[AW-1:0]),
    .rdata_o(rdata),
    .we_i   (done && !s1_full_q),
    .waddr_i(pos_q[AW-1:0]),
    .wdata_i({s1_open_q, prev_run_q})
  );

  always_comb begin
    ctl.full      = s1_full_q;
    ctl.is_close  = s1_close_q;
    ctl.prev_open = prev_open_q;
    ctl.span_ok   = s1_span_q;
    ctl.rd_open   = rdata[LW];
  end

  lbbr_calc #(
    .LW(LW)
  ) u_calc (
    .ctl_i      (ctl),
    .prev_run_i (prev_run_q),
    .prev2_run_i(prev2_run_q),
    .rd_run_i   (rdata[LW-1:0]),
    .best_i     (best_q),
    .hits_i     (hits_q),
    .run_o      (run),
    .best_o     (best_d),
    .hits_o     (hits_d)
  );

  always_comb begin
    s1_valid_d  = s1_valid_q;
    pos_d       = pos_q;
    prev_run_d  = prev_run_q;
    prev2_run_d = prev2_run_q;
    prev_open_d = prev_open_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (done) begin
      s1_valid_d = 1'b0;
    end
    if (done) begin
      out_valid_d = 1'b1;
      if (s1_full_q) begin
        ovf_d = 1'b1;
      end else begin
        pos_d       = pos_q + LW'(1);
        prev_run_d  = run;
        prev2_run_d = prev_run_q;
        prev_open_d = s1_open_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      pos_q       <= '0;
      prev_run_q  <= '0;
      prev2_run_q <= '0;
      prev_open_q <= 1'b0;
      best_q      <= '0;
      hits_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (done && s1_last_q) begin
        pos_q       <= '0;
        prev_run_q  <= '0;
        prev2_run_q <= '0;
        prev_open_q <= 1'b0;
        best_q      <= '0;
        hits_q      <= '0;
        ovf_q       <= 1'b0;
      end else begin
        pos_q       <= pos_d;
        prev_run_q  <= prev_run_d;
        prev2_run_q <= prev2_run_d;
        prev_open_q <= prev_open_d;
        ovf_q       <= ovf_d;
        if (done) begin
          best_q <= best_d;
          hits_q <= hits_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_close_q <= in_data_i.symbol == lbbr_pkg::CLOSE_SYM;
      s1_open_q  <= in_data_i.symbol == lbbr_pkg::OPEN_SYM;
      s1_last_q  <= in_data_i.last;
      s1_full_q  <= pos_q >= LW'(MAX_LEN);
      s1_span_q  <= (prev_run_q != '0) && (prev_run_q < pos_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q.run_length  <= sat_field(run);
      out_q.best_length <= sat_field(best_d);
      out_q.best_count  <= (best_d == '0) ? lbbr_pkg::FIELD_W'(1) : sat_field(hits_d);
      out_q.final_res   <= s1_last_q;
      out_q.too_long    <= ovf_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lbbr_checker.sv
// Port-level checks of the bracket run block and their bind.
`default_nettype none
`include "longest_balanced_bracket_run_macros.svh"

module lbbr_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire lbbr_pkg::in_beat_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire lbbr_pkg::out_beat_t out_data_o
);

  `LBBR_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(in_data_i), "input beat dropped or changed while stalled")
  `LBBR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result beat dropped or changed while stalled")
  `LBBR_ASSERT(a_count_nz, !out_valid_o || (out_data_o.best_count != '0), "best_count is zero")
  `LBBR_ASSERT(a_run_le_best, !out_valid_o || (out_data_o.run_length <= out_data_o.best_length), "run_length above best_length")
  `LBBR_ASSERT_NEXT(a_two_cycle, in_valid_i && in_ready_o, !in_ready_o, "input taken on consecutive cycles")

endmodule

bind longest_balanced_bracket_run lbbr_checker u_lbbr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench of the longest balanced bracket run block.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned MAX_LEN = 4096;
  localparam int unsigned IDLE_PCT = 21;

  typedef enum int {GEN_BALANCED, GEN_BRACKETS, GEN_NOISE} gen_mode_e;

  typedef struct {
    logic [7:0]          symbol;
    logic                last;
    bit                  typed;
    lbbr_pkg::out_beat_t want;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                out_ready_i = 1'b0;
  lbbr_pkg::in_beat_t  in_data_i = '0;
  logic                in_ready_o;
  logic                out_valid_o;
  lbbr_pkg::out_beat_t out_data_o;

  // shadow of the block state
  int unsigned run_mem [MAX_LEN];
  bit          open_mem [MAX_LEN];
  int unsigned str_pos;
  int unsigned prev_run;
  int unsigned best_run;
  int unsigned best_hits;
  bit          str_overflow;

  lbbr_pkg::out_beat_t pending_results [$];
  lbbr_pkg::out_beat_t oldest;
  int                  fail_count = 0;
  int                  rand_items = 0;
  bit                  calm = 1'b0;

  longest_balanced_bracket_run #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned run_at(input int unsigned p);
    if (p == 0 || p > MAX_LEN) return 0;
    return run_mem[p-1];
  endfunction

  function automatic bit open_at(input int unsigned p);
    if (p == 0 || p > MAX_LEN) return 1'b0;
    return open_mem[p-1];
  endfunction

  function automatic logic [lbbr_pkg::FIELD_W-1:0] sat13(input int unsigned v);
    return (v > lbbr_pkg::FIELD_MAX) ? lbbr_pkg::FIELD_MAX : v[lbbr_pkg::FIELD_W-1:0];
  endfunction

  function automatic lbbr_pkg::out_beat_t bracket_step(input logic [7:0] sym,
                                                       input logic last);
    int unsigned         run;
    int unsigned         p;
    int unsigned         j;
    lbbr_pkg::out_beat_t r;
    run = 0;
    if (str_pos >= MAX_LEN) begin
      str_overflow = 1'b1;
    end else begin
      p = str_pos + 1;
      if (sym == lbbr_pkg::CLOSE_SYM) begin
        if (open_at(p - 1)) begin
          run = run_at(p - 2) + 2;
        end else if (prev_run > 0 && prev_run <= p - 1) begin
          j = p - prev_run - 1;
          if (open_at(j)) run = run_at(j - 1) + prev_run + 2;
        end
      end
      run_mem[p-1] = run;
      open_mem[p-1] = (sym == lbbr_pkg::OPEN_SYM);
      str_pos = p;
      prev_run = run;
      if (run == best_run) begin
        best_hits++;
      end else if (run > best_run) begin
        best_run = run;
        best_hits = 1;
      end
    end
    r.run_length = sat13(run);
    r.best_length = sat13(best_run);
    r.best_count = (best_run == 0) ? lbbr_pkg::FIELD_W'(1) : sat13(best_hits);
    r.final_res = last;
    r.too_long = str_overflow;
    if (last) begin
      str_pos = 0;
      prev_run = 0;
      best_run = 0;
      best_hits = 0;
      str_overflow = 1'b0;
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [7:0] sym, input logic last, input bit typed = 1'b0,
                           input lbbr_pkg::out_beat_t want = '0);
    lbbr_pkg::out_beat_t pred;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i.symbol = sym;
    in_data_i.last = last;
    do @(posedge clk_i); while (!in_ready_o);
    pred = bracket_step(sym, last);
    pending_results.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  task automatic send_string(input int len, input gen_mode_e mode);
    int         depth;
    logic [7:0] sym;
    depth = 0;
    for (int i = 0; i < len; i++) begin
      case (mode)
        GEN_BALANCED: begin
          if (depth >= len - i) sym = lbbr_pkg::CLOSE_SYM;
          else if (depth == 0) sym = lbbr_pkg::OPEN_SYM;
          else sym = $urandom_range(0, 1) ? lbbr_pkg::OPEN_SYM : lbbr_pkg::CLOSE_SYM;
          if ($urandom_range(0, 99) < 4) sym = 8'($urandom_range(0, 255));
        end
        GEN_BRACKETS: begin
          sym = $urandom_range(0, 1) ? lbbr_pkg::OPEN_SYM : lbbr_pkg::CLOSE_SYM;
        end
        default: begin
          if ($urandom_range(0, 1)) sym = 8'($urandom_range(0, 255));
          else sym = $urandom_range(0, 1) ? lbbr_pkg::OPEN_SYM : lbbr_pkg::CLOSE_SYM;
        end
      endcase
      if (sym == lbbr_pkg::OPEN_SYM) depth++;
      else if (sym == lbbr_pkg::CLOSE_SYM && depth > 0) depth--;
      send_beat(sym, i == len - 1);
      rand_items++;
      calm = (rand_items >= 300 && rand_items < 450);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i = calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, out_data_o);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("run_length", oldest.run_length, out_data_o.run_length);
        check_field("best_length", oldest.best_length, out_data_o.best_length);
        check_field("best_count", oldest.best_count, out_data_o.best_count);
        check_field("final_res", oldest.final_res, out_data_o.final_res);
        check_field("too_long", oldest.too_long, out_data_o.too_long);
      end
    end
  end

  initial begin
    dir_row_t  dir_rows [24];
    int        r;
    gen_mode_e mode;
    int        len;

    dir_rows = '{
      '{lbbr_pkg::CLOSE_SYM, 1'b0, 1'b1, '{13'd0, 13'd0, 13'd1, 1'b0, 1'b0}},
      '{lbbr_pkg::OPEN_SYM,  1'b0, 1'b1, '{13'd0, 13'd0, 13'd1, 1'b0, 1'b0}},
      '{lbbr_pkg::CLOSE_SYM, 1'b0, 1'b1, '{13'd2, 13'd2, 13'd1, 1'b0, 1'b0}},
      '{lbbr_pkg::OPEN_SYM,  1'b0, 1'b0, '0},
      '{lbbr_pkg::CLOSE_SYM, 1'b0, 1'b0, '0},
      '{8'h00,               1'b0, 1'b0, '0},
      '{lbbr_pkg::OPEN_SYM,  1'b0, 1'b0, '0},
      '{lbbr_pkg::OPEN_SYM,  1'b0, 1'b0, '0},
      '{lbbr_pkg::CLOSE_SYM, 1'b0, 1'b0, '0},
      '{lbbr_pkg::CLOSE_SYM, 1'b0, 1'b0, '0},
      '{8'hFF,               1'b0, 1'b0, '0},
      '{8'hA9,               1'b0, 1'b0, '0},
      '{8'hD7,               1'b0, 1'b0, '0},
      '{lbbr_pkg::CLOSE_SYM, 1'b1, 1'b0, '0},
      '{lbbr_pkg::OPEN_SYM,  1'b1, 1'b1, '{13'd0, 13'd0, 13'd1, 1'b1, 1'b0}},
      '{lbbr_pkg::CLOSE_SYM, 1'b1, 1'b1, '{13'd0, 13'd0, 13'd1, 1'b1, 1'b0}},
      '{8'h55,               1'b0, 1'b0, '0},
      '{8'hAA,               1'b1, 1'b0, '0},
      '{lbbr_pkg::OPEN_SYM,  1'b0, 1'b0, '0},
      '{lbbr_pkg::OPEN_SYM,  1'b0, 1'b0, '0},
      '{lbbr_pkg::CLOSE_SYM, 1'b0, 1'b0, '0},
      '{lbbr_pkg::CLOSE_SYM, 1'b0, 1'b0, '0},
      '{lbbr_pkg::OPEN_SYM,  1'b0, 1'b0, '0},
      '{lbbr_pkg::CLOSE_SYM, 1'b1, 1'b0, '0}
    };

    str_pos = 0;
    prev_run = 0;
    best_run = 0;
    best_hits = 0;
    str_overflow = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].symbol, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

    while (rand_items < 900) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        mode = GEN_BALANCED;
        len = 2 * $urandom_range(1, 20);
      end else begin
        mode = (r < 85) ? GEN_BRACKETS : GEN_NOISE;
        len = $urandom_range(1, 40);
      end
      send_string(len, mode);
    end
    in_valid_i = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/lbbr_pkg.sv
hw/rtl/lbbr_store.sv
hw/rtl/lbbr_calc.sv
hw/rtl/longest_balanced_bracket_run.sv
hw/rtl/lbbr_checker.sv
tb/tb_top.sv
